[src/gls_pkg.sv]
// Shared types, widths and helpers for the greedy list scheduler.
package gls_pkg;

	localparam int MAX_SERVERS = 16;
	localparam int IDX_W       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int CNT_W       = $clog2(MAX_SERVERS + 1);
	localparam int CFG_W       = 5;
	localparam int OUT_IDX_W   = 4;
	localparam int DUR_W       = 16;
	localparam int LOAD_W      = 32;
	localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [DUR_W-1:0] dur;
		logic [CNT_W-1:0] count;
	} qentry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} back_state_t;

	// Servers in use: zero counts as one, anything past the pool is clipped.
	function automatic logic [CNT_W-1:0] servers_in_use(input logic [CFG_W-1:0] mc);
		logic [CFG_W:0] c;
		c = {1'b0, mc};
		if (c == '0)
			c = (CFG_W + 1)'(1);
		if (c > (CFG_W + 1)'(MAX_SERVERS))
			c = (CFG_W + 1)'(MAX_SERVERS);
		return CNT_W'(c);
	endfunction

endpackage

[src/gls_ifs.sv]
// Handshake channel interfaces: job input, result output, configuration write.
interface gls_job_if;
	logic                      valid;
	logic                      ready;
	logic [gls_pkg::DUR_W-1:0] job_duration;

	modport source (output valid, output job_duration, input ready);
	modport sink (input valid, input job_duration, output ready);
endinterface

interface gls_result_if;
	logic                          valid;
	logic                          ready;
	logic [gls_pkg::OUT_IDX_W-1:0] server_index;
	logic [gls_pkg::LOAD_W-1:0]    server_finish;
	logic [gls_pkg::LOAD_W-1:0]    makespan;
	logic                          overflowed;

	modport source (output valid, output server_index, output server_finish,
		output makespan, output overflowed, input ready);
	modport sink (input valid, input server_index, input server_finish,
		input makespan, input overflowed, output ready);
endinterface

interface gls_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [gls_pkg::CFG_W-1:0] machine_count;

	modport source (output valid, output machine_count, input ready);
	modport sink (input valid, input machine_count, output ready);
endinterface

[src/gls_front.sv]
// Front end: holds the server-count register and tags each job with its count.
module gls_front (
	input  logic             clk,
	input  logic             arst_n,
	gls_job_if.sink          jobs,
	gls_cfg_if.sink          cfg,
	output logic             push_valid,
	output gls_pkg::qentry_t push_data,
	input  logic             full
);
	import gls_pkg::*;

	logic [CFG_W-1:0] machine_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			machine_count_q <= CFG_W'(MAX_SERVERS);
		end else if (cfg.valid && cfg.ready) begin
			machine_count_q <= cfg.machine_count;
		end
	end

	assign cfg.ready  = 1'b1;
	assign jobs.ready = !full;

	assign push_valid      = jobs.valid && !full;
	assign push_data.dur   = jobs.job_duration;
	assign push_data.count = servers_in_use(machine_count_q);

endmodule

[src/gls_queue.sv]
// Short job queue between front and back end.
module gls_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	input  gls_pkg::qentry_t push_data,
	output logic             full,
	input  logic             pop,
	output gls_pkg::qentry_t pop_data,
	output logic             empty
);
	import gls_pkg::*;

	qentry_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  fill_q;
	logic               do_push;
	logic               do_pop;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full     = (fill_q == QCNT_W'(QDEPTH));
	assign empty    = (fill_q == '0);
	assign do_push  = push_valid && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

[src/gls_back.sv]
// Back end: scans server loads for the earliest finish and dispatches the job.
module gls_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  gls_pkg::qentry_t pop_data,
	output logic             pop,
	gls_result_if.source     results
);
	import gls_pkg::*;

	back_state_t        state_q, state_d;
	logic [LOAD_W-1:0]  load_q [MAX_SERVERS];
	logic [LOAD_W-1:0]  longest_q;
	logic               sat_q;

	logic [DUR_W-1:0]   dur_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   scan_idx_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [LOAD_W-1:0]  best_val_q;

	logic               out_valid_q;
	logic [OUT_IDX_W-1:0] out_idx_q;
	logic [LOAD_W-1:0]  out_finish_q;
	logic [LOAD_W-1:0]  out_span_q;
	logic               out_ovf_q;

	logic [LOAD_W-1:0]  scan_val;
	logic               scan_last;
	logic [LOAD_W:0]    sum;
	logic               sat_now;
	logic [LOAD_W-1:0]  finish;
	logic [LOAD_W-1:0]  span_new;
	logic               out_free;
	logic               commit;

	assign scan_val  = load_q[scan_idx_q];
	assign scan_last = (CNT_W'(scan_idx_q) == count_q - 1'b1);
	assign sum       = {1'b0, best_val_q} + (LOAD_W + 1)'(dur_q);
	assign sat_now   = sum[LOAD_W];
	assign finish    = sat_now ? LOAD_MAX : sum[LOAD_W-1:0];
	assign span_new  = (finish > longest_q) ? finish : longest_q;
	assign out_free  = !out_valid_q || results.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!empty)
					state_d = (pop_data.count == CNT_W'(1)) ? ST_UPDATE : ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_last)
					state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		pop    = 1'b0;
		commit = 1'b0;
		case (state_q)
			ST_IDLE:   pop = !empty;
			ST_UPDATE: commit = out_free;
			default: begin
				pop    = 1'b0;
				commit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			longest_q   <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_SERVERS; i++)
				load_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				load_q[best_idx_q] <= finish;
				longest_q          <= span_new;
				sat_q              <= sat_q || sat_now;
				out_valid_q        <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			dur_q      <= pop_data.dur;
			count_q    <= pop_data.count;
			best_idx_q <= '0;
			best_val_q <= load_q[0];
			scan_idx_q <= IDX_W'(1);
		end else if (state_q == ST_SCAN) begin
			// strict less-than keeps the lowest index on a tie
			if (scan_val < best_val_q) begin
				best_val_q <= scan_val;
				best_idx_q <= scan_idx_q;
			end
			scan_idx_q <= scan_idx_q + 1'b1;
		end
		if (commit) begin
			out_idx_q    <= OUT_IDX_W'(best_idx_q);
			out_finish_q <= finish;
			out_span_q   <= span_new;
			out_ovf_q    <= sat_q || sat_now;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.server_index  = out_idx_q;
	assign results.server_finish = out_finish_q;
	assign results.makespan      = out_span_q;
	assign results.overflowed    = out_ovf_q;

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (CNT_W'(scan_idx_q) < count_q))
		else $error("scan index past server count");

	a_best_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |-> (CNT_W'(best_idx_q) < count_q))
		else $error("chosen server outside active set");

	a_span_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (longest_q >= $past(longest_q)))
		else $error("makespan decreased");

	a_sat_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		sat_q |=> sat_q)
		else $error("overflow flag cleared");

	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> (!out_valid_q || results.ready))
		else $error("result overwritten before taken");

endmodule

[src/greedy_list_scheduler_top.sv]
// Top level of the greedy list scheduler: front end, job queue and back end.
// Each job goes to the in-use server with the smallest finish time (lowest
// index on a tie); the result gives that server, its new finish time, the
// makespan and a sticky saturation flag. The servers in use number N
// (machine_count, with zero read as one and anything above sixteen as
// sixteen). In the back end a job is pulled from the queue as server 0 is
// read, the single load comparator walks the load registers of the further
// servers, and an update step writes the result once the output is free.
// A two-entry queue lets new jobs in while the back end works, and an output
// register holds a result until it is taken. The server count is sampled
// when a job enters; write it only while the block is idle.
module greedy_list_scheduler_top (
	input logic          clk,
	input logic          arst_n,
	gls_job_if.sink      jobs,
	gls_result_if.source results,
	gls_cfg_if.sink      cfg
);
	import gls_pkg::*;

	logic    push_valid;
	qentry_t push_data;
	logic    full;
	logic    pop;
	qentry_t pop_data;
	logic    empty;

	gls_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.jobs       (jobs),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_data  (push_data),
		.full       (full)
	);

	gls_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.full       (full),
		.pop        (pop),
		.pop_data   (pop_data),
		.empty      (empty)
	);

	gls_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.pop_data (pop_data),
		.pop      (pop),
		.results  (results)
	);

endmodule

[tb/gls_dispatch_checker.sv]
// Dispatch checker: tracks server finish times and checks each result item.
module gls_dispatch_checker (
	input  logic  clk,
	input  logic  arst_n,
	gls_job_if    jobs,
	gls_result_if results,
	gls_cfg_if    cfg,
	output int    error_count,
	output int    results_owed
);
	import gls_pkg::*;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] server_index;
		logic [LOAD_W-1:0]    server_finish;
		logic [LOAD_W-1:0]    makespan;
		logic                 overflowed;
	} dispatch_t;

	logic [LOAD_W-1:0] finish_time [MAX_SERVERS];
	logic [LOAD_W-1:0] longest_finish;
	logic              saturated;
	logic [CFG_W-1:0]  server_count;
	dispatch_t         dispatch_q[$];
	dispatch_t         oldest;
	int                fails = 0;

	// Earliest-finish server among those in use; updates the tracked loads.
	function automatic dispatch_t dispatch_job(input logic [DUR_W-1:0] dur);
		int          active;
		int          best;
		logic [LOAD_W:0] sum;
		dispatch_t   d;
		active = server_count;
		if (active == 0)
			active = 1;
		if (active > MAX_SERVERS)
			active = MAX_SERVERS;
		best = 0;
		for (int i = 1; i < active; i++) begin
			if (finish_time[i] < finish_time[best])
				best = i;
		end
		sum = {1'b0, finish_time[best]} + (LOAD_W + 1)'(dur);
		if (sum > {1'b0, LOAD_MAX}) begin
			sum = {1'b0, LOAD_MAX};
			saturated = 1'b1;
		end
		finish_time[best] = sum[LOAD_W-1:0];
		if (finish_time[best] > longest_finish)
			longest_finish = finish_time[best];
		d.server_index  = OUT_IDX_W'(best);
		d.server_finish = finish_time[best];
		d.makespan      = longest_finish;
		d.overflowed    = saturated;
		return d;
	endfunction

	task automatic check_field(input string name, input logic [LOAD_W-1:0] want,
		input logic [LOAD_W-1:0] got);
		if (got !== want) begin
			fails++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (finish_time[i])
				finish_time[i] = '0;
			longest_finish = '0;
			saturated      = 1'b0;
			server_count   = CFG_W'(MAX_SERVERS);
			dispatch_q.delete();
			results_owed <= 0;
		end else begin
			if (cfg.valid && cfg.ready)
				server_count = cfg.machine_count;
			// results leave before this edge's job can be counted
			if (results.valid && results.ready) begin
				if (dispatch_q.size() == 0) begin
					fails++;
					$display("%0t: unexpected result, expected none, got %0d %0d %0d %0b",
						$time, results.server_index, results.server_finish,
						results.makespan, results.overflowed);
				end else begin
					oldest = dispatch_q.pop_front();
					check_field("server_index", LOAD_W'(oldest.server_index),
						LOAD_W'(results.server_index));
					check_field("server_finish", oldest.server_finish,
						results.server_finish);
					check_field("makespan", oldest.makespan, results.makespan);
					check_field("overflowed", LOAD_W'(oldest.overflowed),
						LOAD_W'(results.overflowed));
				end
			end
			if (jobs.valid && jobs.ready)
				dispatch_q.push_back(dispatch_job(jobs.job_duration));
			results_owed <= dispatch_q.size();
			error_count  <= fails;
		end
	end

endmodule

[tb/greedy_list_scheduler_top_tb.sv]
// Testbench top: clock, reset, job and count stimulus, handshake idling, verdict.
module greedy_list_scheduler_top_tb;
	import gls_pkg::*;

	localparam int CYCLE_LIMIT      = 1_000_000;
	localparam int RANDOM_PER_PHASE = 56;
	localparam int PHASES           = 8;
	localparam int PILE_JOBS        = 16;
	localparam int DRAIN_CYCLES     = 40;

	typedef enum int {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	logic clk;
	logic arst_n;
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	int   cycles         = 0;
	int   error_count;
	int   results_owed;

	gls_job_if    job_ch ();
	gls_result_if res_ch ();
	gls_cfg_if    cfg_ch ();

	greedy_list_scheduler_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.jobs    (job_ch),
		.results (res_ch),
		.cfg     (cfg_ch)
	);

	gls_dispatch_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.jobs         (job_ch),
		.results      (res_ch),
		.cfg          (cfg_ch),
		.error_count  (error_count),
		.results_owed (results_owed)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_SEND: begin
				send_idle_pct  = 60;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_idle_pct  = 0;
				recv_stall_pct = 60;
			end
			IDLE_BOTH: begin
				send_idle_pct  = 28;
				recv_stall_pct = 28;
			end
			default: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
		endcase
	endtask

	// valid stays high across back-to-back items; the caller drops it at the end
	task automatic send_job(input logic [DUR_W-1:0] dur);
		while ($urandom_range(99) < send_idle_pct) begin
			job_ch.valid <= 1'b0;
			@(posedge clk);
		end
		job_ch.valid        <= 1'b1;
		job_ch.job_duration <= dur;
		@(posedge clk);
		while (!job_ch.ready)
			@(posedge clk);
	endtask

	task automatic write_server_count(input logic [CFG_W-1:0] count);
		cfg_ch.valid         <= 1'b1;
		cfg_ch.machine_count <= count;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// drop valid and let the checker see the last accepted job before polling
	task automatic wait_drained();
		job_ch.valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
	endtask

	function automatic logic [DUR_W-1:0] pick_duration();
		int pick;
		pick = $urandom_range(99);
		if (pick < 60)
			return DUR_W'($urandom);
		else if (pick < 85)
			return DUR_W'($urandom_range(8));
		else if (pick < 93)
			return '1;
		else
			return DUR_W'($urandom_range(1));
	endfunction

	initial begin
		logic [CFG_W-1:0] count;
		job_ch.valid         = 1'b0;
		job_ch.job_duration  = '0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.machine_count = '0;
		arst_n               = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset count of sixteen; zero duration, field extremes, then ties
		send_job('0);
		send_job(DUR_W'(1));
		send_job('1);
		send_job(16'h5555);
		send_job(16'hAAAA);
		send_job(16'h8000);
		send_job(16'h7FFF);
		repeat (12) send_job(DUR_W'(100));
		wait_drained();

		// counts change between phases; loads carry over
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: count = CFG_W'(MAX_SERVERS);
				1: count = '0;
				2: count = '1;
				3: count = CFG_W'(1);
				4: count = CFG_W'(3);
				5: count = CFG_W'(MAX_SERVERS + 1);
				default: count = CFG_W'($urandom_range(31));
			endcase
			write_server_count(count);
			set_idling(idle_mode_t'(p % 4));
			repeat (RANDOM_PER_PHASE) send_job(pick_duration());
			wait_drained();
		end

		// pile full-length jobs on one server, then zero-length ones
		set_idling(IDLE_NONE);
		write_server_count(CFG_W'(1));
		repeat (PILE_JOBS) send_job('1);
		repeat (2) send_job('0);
		wait_drained();
		write_server_count(CFG_W'(MAX_SERVERS));
		set_idling(IDLE_BOTH);
		repeat (16) send_job(pick_duration());
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && results_owed == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
